// ===== design/ukcr_pkg.sv =====
// ----------------------------------------------------------------------------
// ukcr_pkg
// Shared types, constants and the keyword table of the UART keyword command
// recognizer.
// ----------------------------------------------------------------------------
package ukcr_pkg;

    // Default number of token slots; at most one less is stored.
    localparam int TOKEN_CAPACITY_DEF = 40;

    // Idle flush threshold after reset, in ticks.
    localparam int IDLE_W = 16;
    localparam logic [IDLE_W-1:0] IDLE_FLUSH_RESET = 16'd250;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 4;

    // Item kind carried on the input channel.
    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    // Event reported for a closed token.
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_COMMAND = 2'd1,
        EV_UNKNOWN = 2'd2,
        EV_DROPPED = 2'd3
    } event_t;

    typedef logic [CODE_W-1:0] code_t;

    // Command codes.
    localparam code_t CODE_STATUS  = 4'd0;
    localparam code_t CODE_QUOTA   = 4'd1;
    localparam code_t CODE_TASKS   = 4'd2;
    localparam code_t CODE_CLOCK   = 4'd3;
    localparam code_t CODE_REFRESH = 4'd4;
    localparam code_t CODE_BRIDGE  = 4'd5;
    localparam code_t CODE_QON     = 4'd6;
    localparam code_t CODE_QOFF    = 4'd7;
    localparam code_t CODE_START   = 4'd8;
    localparam code_t CODE_STOP    = 4'd9;
    localparam code_t CODE_LAST    = CODE_STOP;

    // Keyword table. Text is right-justified, first character in the
    // highest used byte, zero padded above.
    localparam int KW_COUNT   = 18;
    localparam int KW_MAX_LEN = 13;
    localparam int KW_LEN_W   = 4;

    typedef logic [KW_MAX_LEN*BYTE_W-1:0] kw_text_t;

    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        kw_text_t'({"voice_", "status"}),
        kw_text_t'("status"),
        kw_text_t'({"show_", "quota"}),
        kw_text_t'("quota"),
        kw_text_t'({"show_", "tasks"}),
        kw_text_t'("tasks"),
        kw_text_t'({"show_", "clock"}),
        kw_text_t'("clock"),
        kw_text_t'({"refresh_", "state"}),
        kw_text_t'("refresh"),
        kw_text_t'({"bridge_", "match"}),
        kw_text_t'({"match_", "bridge"}),
        kw_text_t'({"quiet_", "on"}),
        kw_text_t'({"quiet_", "off"}),
        // Long form of the start command, spelled in hex.
        kw_text_t'(104'h78_69_61_6f_7a_68_69_5f_73_74_61_72_74),
        kw_text_t'({"ai_", "start"}),
        // Long form of the stop command, spelled in hex.
        kw_text_t'(96'h78_69_61_6f_7a_68_69_5f_73_74_6f_70),
        kw_text_t'("ai_stop")
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd12, 4'd6, 4'd10, 4'd5, 4'd10, 4'd5, 4'd10, 4'd5, 4'd13,
        4'd7, 4'd12, 4'd12, 4'd8, 4'd9, 4'd13, 4'd8, 4'd12, 4'd7
    };

    localparam code_t KW_CODE [KW_COUNT] = '{
        CODE_STATUS, CODE_STATUS, CODE_QUOTA, CODE_QUOTA,
        CODE_TASKS, CODE_TASKS, CODE_CLOCK, CODE_CLOCK,
        CODE_REFRESH, CODE_REFRESH, CODE_BRIDGE, CODE_BRIDGE,
        CODE_QON, CODE_QOFF, CODE_START, CODE_START, CODE_STOP, CODE_STOP
    };

    // Character j of keyword k, or zero past its end.
    function automatic logic [BYTE_W-1:0] kw_char(input int k, input int j);
        int len;
        len = int'(KW_LEN[k]);
        if (j < len)
        begin
            return KW_TEXT[k][BYTE_W*(len-1-j) +: BYTE_W];
        end
        return '0;
    endfunction

endpackage

// ===== design/ukcr_in_if.sv =====
// ----------------------------------------------------------------------------
// ukcr_in_if
// Input channel: one received byte or one time tick per transaction.
// ----------------------------------------------------------------------------
interface ukcr_in_if;
    import ukcr_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [BYTE_W-1:0]   byte_value;

    modport source (output valid, output command, output byte_value, input ready);
    modport sink   (input valid, input command, input byte_value, output ready);
endinterface

// ===== design/ukcr_out_if.sv =====
// ----------------------------------------------------------------------------
// ukcr_out_if
// Result channel: one token event per transaction.
// ----------------------------------------------------------------------------
interface ukcr_out_if;
    import ukcr_pkg::*;

    logic     valid;
    logic     ready;
    event_t   event_res;
    code_t    command_code;

    modport source (output valid, output event_res, output command_code, input ready);
    modport sink   (input valid, input event_res, input command_code, output ready);
endinterface

// ===== design/uart_keyword_command_recognizer_unit.sv =====
// ----------------------------------------------------------------------------
// uart_keyword_command_recognizer_unit
// Builds tokens from received bytes, closes them on delimiters or idle ticks
// and matches them against a fixed keyword table, one item per cycle while ready.
// ----------------------------------------------------------------------------
// A result is registered in the output register, or in the skid entry.
// Throughput: one item per cycle while the skid entry is empty; keyword prefixes
//   are tracked per character, so closing a token is a single length compare.
// An output register plus a skid entry keep input ready while one result waits.
// Reset: asynchronous, active low; clears the token, idle counter and output
//   entries and loads the idle threshold with 250 ticks.
module uart_keyword_command_recognizer_unit #(
    parameter int TOKEN_CAPACITY = ukcr_pkg::TOKEN_CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ukcr_in_if.sink                       in_ch,
    ukcr_out_if.source                    out_ch,
    input  logic                          cfg_we,
    input  logic [ukcr_pkg::IDLE_W-1:0]   cfg_wdata
);
    import ukcr_pkg::*;

    localparam int LEN_W = $clog2(TOKEN_CAPACITY);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(TOKEN_CAPACITY - 1);

    // Character classes.
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_DIG_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIG_9 = 8'h39;
    localparam logic [BYTE_W-1:0] CASE_OFS = 8'h20;
    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    // Token and idle state.
    logic [LEN_W-1:0]     tok_len_reg, tok_len_next;
    logic                 ovf_reg, ovf_next;
    logic [KW_COUNT-1:0]  alive_reg, alive_next;
    logic [IDLE_W-1:0]    idle_cnt_reg, idle_cnt_next;
    logic [IDLE_W-1:0]    idle_flush_reg;

    // Output register and skid entry.
    logic                 out_valid_reg, out_valid_next;
    event_t               out_ev_reg, out_ev_next;
    code_t                out_code_reg, out_code_next;
    logic                 skid_valid_reg, skid_valid_next;
    event_t               skid_ev_reg, skid_ev_next;
    code_t                skid_code_reg, skid_code_next;

    logic                 in_acc;
    logic                 is_tick;
    logic [BYTE_W-1:0]    ch_fold;
    logic                 is_delim;
    logic                 is_keep;
    logic                 tok_full;
    logic [IDLE_W-1:0]    idle_inc;
    logic                 tick_close;
    logic                 do_close;
    logic [KW_COUNT-1:0]  char_hit;
    logic [KW_COUNT-1:0]  kw_hit;
    logic                 kw_found;
    code_t                kw_code;
    event_t               close_ev;
    code_t                close_code;
    logic                 res_valid;
    logic                 out_take;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign is_tick  = (in_ch.command == KIND_TICK);
    assign in_ch.ready = !skid_valid_reg;
    assign out_take = out_valid_reg && out_ch.ready;

    // Classify the byte and fold upper case to lower case.
    always_comb
    begin
        ch_fold = in_ch.byte_value;
        if (in_ch.byte_value >= CH_UP_A && in_ch.byte_value <= CH_UP_Z)
        begin
            ch_fold = in_ch.byte_value + CASE_OFS;
        end
        is_delim = (in_ch.byte_value <= CH_SPACE) || (in_ch.byte_value == CH_COMMA)
                   || (in_ch.byte_value == CH_SEMI);
        is_keep  = (ch_fold >= CH_LO_A && ch_fold <= CH_LO_Z)
                   || (ch_fold >= CH_DIG_0 && ch_fold <= CH_DIG_9)
                   || (ch_fold == CH_UNDER) || (ch_fold == CH_DASH);
    end

    // Saturating idle increment and the idle flush decision.
    assign idle_inc   = (idle_cnt_reg == IDLE_MAX) ? idle_cnt_reg : idle_cnt_reg + IDLE_W'(1);
    assign tick_close = (tok_len_reg != '0) && (idle_inc >= idle_flush_reg);
    assign do_close   = in_acc && (is_tick ? tick_close : is_delim);
    assign tok_full   = (tok_len_reg >= LEN_FULL);

    // Per keyword: does the incoming character match at the current position.
    always_comb
    begin
        char_hit = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            for (int j = 0; j < KW_MAX_LEN; j++)
            begin
                if ((tok_len_reg == LEN_W'(j)) && (j < int'(KW_LEN[k]))
                    && (kw_char(k, j) == ch_fold))
                begin
                    char_hit[k] = 1'b1;
                end
            end
        end
    end

    // Full match on close: prefix still alive and the length agrees.
    always_comb
    begin
        kw_found = 1'b0;
        kw_code  = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            kw_hit[k] = alive_reg[k] && (tok_len_reg == LEN_W'(KW_LEN[k]));
            if (!kw_found && kw_hit[k])
            begin
                kw_found = 1'b1;
                kw_code  = KW_CODE[k];
            end
        end
    end

    // Event for the token being closed.
    always_comb
    begin
        close_ev   = EV_NONE;
        close_code = '0;
        priority if (tok_len_reg == '0)
        begin
            close_ev = EV_NONE;
        end
        else if (ovf_reg)
        begin
            close_ev = EV_DROPPED;
        end
        else if (kw_found)
        begin
            close_ev   = EV_COMMAND;
            close_code = kw_code;
        end
        else
        begin
            close_ev = EV_UNKNOWN;
        end
    end

    assign res_valid = do_close && (close_ev != EV_NONE);

    // Next token and idle state.
    always_comb
    begin
        tok_len_next  = tok_len_reg;
        ovf_next      = ovf_reg;
        alive_next    = alive_reg;
        idle_cnt_next = idle_cnt_reg;
        if (in_acc)
        begin
            idle_cnt_next = is_tick ? idle_inc : '0;
        end
        priority if (do_close)
        begin
            tok_len_next = '0;
            ovf_next     = 1'b0;
            alive_next   = '1;
        end
        else
        begin
            if (in_acc && !is_tick && is_keep)
            begin
                if (tok_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    tok_len_next = tok_len_reg + LEN_W'(1);
                    alive_next   = alive_reg & char_hit;
                end
            end
        end
    end

    // Output register with a skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_ev_next     = out_ev_reg;
        out_code_next   = out_code_reg;
        skid_valid_next = skid_valid_reg;
        skid_ev_next    = skid_ev_reg;
        skid_code_next  = skid_code_reg;
        priority if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_ev_next     = skid_ev_reg;
                out_code_next   = skid_code_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_next = res_valid;
            out_ev_next    = close_ev;
            out_code_next  = close_code;
        end
        else
        begin
            if (res_valid)
            begin
                skid_valid_next = 1'b1;
                skid_ev_next    = close_ev;
                skid_code_next  = close_code;
            end
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_len_reg    <= '0;
            ovf_reg        <= 1'b0;
            alive_reg      <= '1;
            idle_cnt_reg   <= '0;
            idle_flush_reg <= IDLE_FLUSH_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            tok_len_reg    <= tok_len_next;
            ovf_reg        <= ovf_next;
            alive_reg      <= alive_next;
            idle_cnt_reg   <= idle_cnt_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_we)
            begin
                idle_flush_reg <= cfg_wdata;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        out_ev_reg    <= out_ev_next;
        out_code_reg  <= out_code_next;
        skid_ev_reg   <= skid_ev_next;
        skid_code_reg <= skid_code_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.event_res    = out_ev_reg;
    assign out_ch.command_code = out_code_reg;

endmodule

// ===== design/ukcr_checker.sv =====
// ----------------------------------------------------------------------------
// ukcr_checker
// Port-level checks of the keyword recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module ukcr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input ukcr_pkg::event_t              out_event,
    input ukcr_pkg::code_t               out_code
);
    import ukcr_pkg::*;

    // A new result only follows an accepted input transaction.
    a_result_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared without an accepted input");

    // With nothing waiting on the output, the input side must be open.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_event)
                                       && $stable(out_code)))
        else $error("stalled result changed");

    // A recognized command carries a code from the table, others carry zero.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_event == EV_COMMAND && out_code <= CODE_LAST)
                       || (out_event != EV_COMMAND && out_code == '0)))
        else $error("command code out of range");

endmodule

bind uart_keyword_command_recognizer_unit ukcr_checker u_ukcr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_event (out_ch.event_res),
    .out_code  (out_ch.command_code)
);
